FILE: sv/swsq_pkg.sv
// Package for the per-destination send window block.
// Holds sizes, request and status codes, the slot and result records
// and the effective window size function. No dependencies.
package swsq_pkg;

  // Geometry
  localparam int WINDOW_MAX = 16;
  localparam int NUM_DEST   = 16;
  localparam int SLOT_W     = $clog2(WINDOW_MAX);
  localparam int DEST_W     = $clog2(NUM_DEST);
  localparam int ADDR_W     = DEST_W + SLOT_W;
  localparam int DEPTH      = NUM_DEST * WINDOW_MAX;
  localparam int CNT_W      = 5;

  // Configuration
  localparam logic [CNT_W-1:0] SLOT_LIMIT_RESET = 5'd8;
  localparam logic             REG_SLOT_LIMIT   = 1'b0;

  // Request codes
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_DROP   = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_FIND   = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_BEYOND    = 2'd3;

  // One slot of the window storage
  typedef struct packed {
    logic [31:0] timeout;
    logic [15:0] handle;
    logic [7:0]  seq;
  } slot_t;

  // One result item
  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] window_length;
    logic [7:0]       slot_seq;
    logic [15:0]      slot_handle;
    logic [31:0]      slot_timeout;
    logic [3:0]       slot_position;
    logic [CNT_W-1:0] dropped_count;
  } result_t;

  // Window size clamped to 1..WINDOW_MAX
  function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] sz);
    logic [CNT_W-1:0] r;
    r = sz;
    if (sz == '0) r = CNT_W'(1);
    else if (sz > CNT_W'(WINDOW_MAX)) r = CNT_W'(WINDOW_MAX);
    return r;
  endfunction

endpackage

FILE: sv/sliding_window_send_queues.sv
// Per-destination circular send windows, top level.
// Depends on swsq_pkg (sizes, codes, slot and result records).
//
// Usage
//   in_*  : request stream. in_tuser = req_type; in_tdata carries dest_id,
//           count_or_index, entry_seq, entry_handle, entry_timeout.
//   out_* : one result per request. out_tuser = status; out_tdata carries
//           window_length, slot_seq, slot_handle, slot_timeout,
//           slot_position, dropped_count.
//   cfg_* : APB slot limit register at byte address 0 (clamped to 1..16).
// Flow: one request at a time. A request passes a load state, then the
//   shared subtract/compare unit reduces start+offset modulo the window
//   size by repeated subtraction, then: append and drop finish at once,
//   read waits for the registered memory read (RDWAIT, RDRSP states), find
//   walks the slot memory one slot per cycle. A last state (DONE) moves
//   the result into the output register.
// Reset empties every window at once (start and length flops); slot
//   storage is not cleared. The slot limit resets to 8.
// A stalled receiver holds the result in the output register; the block
//   still accepts and works the next request and waits before delivery.
module sliding_window_send_queues (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] dest_id, [8:4] count_or_index, [16:9] entry_seq,
  // [32:17] entry_handle, [64:33] entry_timeout, [71:65] zero
  input  logic [71:0] in_tdata,
  // [1:0] req_type
  input  logic [1:0]  in_tuser,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] window_length, [12:5] slot_seq, [28:13] slot_handle,
  // [60:29] slot_timeout, [64:61] slot_position, [69:65] dropped_count,
  // [71:70] zero
  output logic [71:0] out_tdata,
  // [1:0] status
  output logic [1:0]  out_tuser,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SW = swsq_pkg::SLOT_W;
  localparam int DW = swsq_pkg::DEST_W;
  localparam int CW = swsq_pkg::CNT_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_RDRSP  = 3'd4;
  localparam logic [2:0] S_FIND   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    req_r;
  logic [DW-1:0] dest_r;
  logic [CW-1:0] ci_r;
  logic [7:0]    seq_r;
  logic [15:0]   handle_r;
  logic [31:0]   tmo_r;

  logic [CW-1:0] size_r;
  logic [CW-1:0] eff_s;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] v_r, v_nxt;
  logic [CW-1:0] drop_r, drop_nxt;
  logic [SW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic [SW-1:0] cmp_ptr_r, cmp_ptr_nxt;
  logic [SW-1:0] cmp_i_r, cmp_i_nxt;

  swsq_pkg::result_t res_r, res_nxt;
  swsq_pkg::result_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  // window pointers and lengths, one per destination
  logic [SW-1:0] win_start_r [swsq_pkg::NUM_DEST];
  logic [CW-1:0] win_count_r [swsq_pkg::NUM_DEST];
  logic          win_we;
  logic [SW-1:0] win_start_wr;
  logic [CW-1:0] win_count_wr;
  logic [SW-1:0] start_rd;
  logic [CW-1:0] count_rd;

  // slot memory
  swsq_pkg::slot_t                 mem [swsq_pkg::DEPTH];
  swsq_pkg::slot_t                 rdata_r;
  logic                            mem_we;
  logic [swsq_pkg::ADDR_W-1:0]     mem_waddr;
  swsq_pkg::slot_t                 mem_wdata;
  logic [swsq_pkg::ADDR_W-1:0]     rd_addr;

  logic          in_xfer;
  logic          cfg_wr;
  logic [CW-1:0] ld_drop;
  logic          issue;
  logic [CW-1:0] ptr_inc;
  logic [SW-1:0] ptr_wrap;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign eff_s      = swsq_pkg::eff_size(size_r);
  assign start_rd   = win_start_r[dest_r];
  assign count_rd   = win_count_r[dest_r];
  assign rd_addr    = {dest_r, ptr_r};
  assign ld_drop    = (ci_r < count_rd) ? ci_r : count_rd;
  assign issue      = (iss_r < cnt_r);
  assign ptr_inc    = {1'b0, ptr_r} + CW'(1);
  assign ptr_wrap   = (ptr_inc == eff_s) ? '0 : ptr_inc[SW-1:0];

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == swsq_pkg::REG_SLOT_LIMIT) ?
                      {{(32-CW){1'b0}}, size_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= swsq_pkg::SLOT_LIMIT_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == swsq_pkg::REG_SLOT_LIMIT)) begin
      size_r <= cfg_pwdata[CW-1:0];
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r    <= in_tuser;
      dest_r   <= in_tdata[3:0];
      ci_r     <= in_tdata[8:4];
      seq_r    <= in_tdata[16:9];
      handle_r <= in_tdata[32:17];
      tmo_r    <= in_tdata[64:33];
    end
  end

  // Sequencer and shared reduce/compare unit
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    v_nxt         = v_r;
    drop_nxt      = drop_r;
    ptr_nxt       = ptr_r;
    iss_nxt       = iss_r;
    cmp_v_nxt     = 1'b0;
    cmp_ptr_nxt   = cmp_ptr_r;
    cmp_i_nxt     = cmp_i_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we        = 1'b0;
    mem_waddr     = {dest_r, v_r[SW-1:0]};
    mem_wdata     = '{timeout: tmo_r, handle: handle_r, seq: seq_r};
    win_we        = 1'b0;
    win_start_wr  = start_rd;
    win_count_wr  = cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_LOAD;
      end

      // fetch window state, check bounds, set up start+offset
      S_LOAD: begin
        cnt_nxt = count_rd;
        res_nxt = '0;
        res_nxt.window_length = count_rd;
        unique case (req_r)
          swsq_pkg::REQ_APPEND: begin
            if (count_rd >= eff_s) begin
              res_nxt.status = swsq_pkg::STAT_FULL;
              state_nxt      = S_DONE;
            end else begin
              v_nxt     = {1'b0, start_rd} + count_rd;
              state_nxt = S_MOD;
            end
          end
          swsq_pkg::REQ_DROP: begin
            drop_nxt  = ld_drop;
            v_nxt     = {1'b0, start_rd} + ld_drop;
            state_nxt = S_MOD;
          end
          swsq_pkg::REQ_READ: begin
            if (ci_r >= count_rd) begin
              res_nxt.status = swsq_pkg::STAT_BEYOND;
              state_nxt      = S_DONE;
            end else begin
              v_nxt     = {1'b0, start_rd} + ci_r;
              state_nxt = S_MOD;
            end
          end
          default: begin
            if (count_rd == '0) begin
              res_nxt.status = swsq_pkg::STAT_NOT_FOUND;
              state_nxt      = S_DONE;
            end else begin
              v_nxt     = {1'b0, start_rd};
              state_nxt = S_MOD;
            end
          end
        endcase
      end

      // reduce modulo window size, one subtract a cycle, then act
      S_MOD: begin
        if (v_r >= eff_s) begin
          v_nxt = v_r - eff_s;
        end else begin
          unique case (req_r)
            swsq_pkg::REQ_APPEND: begin
              mem_we                = 1'b1;
              win_we                = 1'b1;
              win_count_wr          = cnt_r + CW'(1);
              res_nxt.window_length = cnt_r + CW'(1);
              state_nxt             = S_DONE;
            end
            swsq_pkg::REQ_DROP: begin
              win_we                = 1'b1;
              win_start_wr          = v_r[SW-1:0];
              win_count_wr          = cnt_r - drop_r;
              res_nxt.window_length = cnt_r - drop_r;
              res_nxt.dropped_count = drop_r;
              state_nxt             = S_DONE;
            end
            swsq_pkg::REQ_READ: begin
              ptr_nxt   = v_r[SW-1:0];
              state_nxt = S_RDWAIT;
            end
            default: begin
              ptr_nxt   = v_r[SW-1:0];
              iss_nxt   = '0;
              state_nxt = S_FIND;
            end
          endcase
        end
      end

      S_RDWAIT: begin
        state_nxt = S_RDRSP;
      end

      S_RDRSP: begin
        res_nxt.slot_seq     = rdata_r.seq;
        res_nxt.slot_handle  = rdata_r.handle;
        res_nxt.slot_timeout = rdata_r.timeout;
        state_nxt            = S_DONE;
      end

      // walk slots: read one per cycle, compare the one read last cycle
      S_FIND: begin
        if (issue) begin
          cmp_v_nxt   = 1'b1;
          cmp_ptr_nxt = ptr_r;
          cmp_i_nxt   = iss_r[SW-1:0];
          iss_nxt     = iss_r + CW'(1);
          ptr_nxt     = ptr_wrap;
        end
        if (cmp_v_r && (rdata_r.seq == seq_r)) begin
          mem_we                = 1'b1;
          mem_waddr             = {dest_r, cmp_ptr_r};
          mem_wdata             = '{timeout: tmo_r, handle: rdata_r.handle,
                                    seq: rdata_r.seq};
          res_nxt.status        = swsq_pkg::STAT_OK;
          res_nxt.slot_seq      = rdata_r.seq;
          res_nxt.slot_handle   = rdata_r.handle;
          res_nxt.slot_timeout  = tmo_r;
          res_nxt.slot_position = cmp_i_r;
          cmp_v_nxt             = 1'b0;
          state_nxt             = S_DONE;
        end else if (cmp_v_r && ({1'b0, cmp_i_r} == (cnt_r - CW'(1)))) begin
          res_nxt.status = swsq_pkg::STAT_NOT_FOUND;
          cmp_v_nxt      = 1'b0;
          state_nxt      = S_DONE;
        end
      end

      // hand result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
      iss_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_v_r     <= cmp_v_nxt;
      iss_r       <= iss_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    v_r       <= v_nxt;
    drop_r    <= drop_nxt;
    ptr_r     <= ptr_nxt;
    cmp_ptr_r <= cmp_ptr_nxt;
    cmp_i_r   <= cmp_i_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  // Window pointers and lengths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < swsq_pkg::NUM_DEST; k++) begin
        win_start_r[k] <= '0;
        win_count_r[k] <= '0;
      end
    end else if (win_we) begin
      win_start_r[dest_r] <= win_start_wr;
      win_count_r[dest_r] <= win_count_wr;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[rd_addr];
  end

  // Output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {2'b00, out_r.dropped_count, out_r.slot_position,
                       out_r.slot_timeout, out_r.slot_handle, out_r.slot_seq,
                       out_r.window_length};

  // Assertions
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_LOAD))
    else $error("accepted request did not start a load");

  a_ptr_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIND) || (state_r == S_RDWAIT)) |-> ({1'b0, ptr_r} < eff_s))
    else $error("slot pointer not reduced below window size");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND) |-> (iss_r <= cnt_r))
    else $error("find walked past window length");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (count_rd <= CW'(swsq_pkg::WINDOW_MAX)))
    else $error("window length above maximum");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == swsq_pkg::STAT_FULL)) |->
    (out_r.window_length != '0))
    else $error("window reported full with zero length");

endmodule

FILE: test/tb_sliding_window_send_queues.sv
`timescale 1ns / 1ps
// Self-checking testbench for the per-destination send window block.
// Streams requests, writes the slot limit over APB and checks every result against
// a behavioral window model. Depends on swsq_pkg and sliding_window_send_queues.
module tb_sliding_window_send_queues;

  localparam int ITEMS_PER_PHASE = 180;
  localparam int FOCUS_DESTS     = 3;
  localparam logic [2:0] ADDR_SLOT_LIMIT = {swsq_pkg::REG_SLOT_LIMIT, 2'b00};
  localparam logic [2:0] ADDR_UNUSED     = 3'd4;

  // One request as carried on the input stream
  typedef struct packed {
    logic [1:0]  req;
    logic [3:0]  dest;
    logic [4:0]  ci;
    logic [7:0]  seq;
    logic [15:0] handle;
    logic [31:0] tmo;
  } win_req_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sliding_window_send_queues i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Window model state
  logic [3:0]  win_start [swsq_pkg::NUM_DEST];
  logic [4:0]  win_count [swsq_pkg::NUM_DEST];
  logic [7:0]  slot_seq_mem [swsq_pkg::DEPTH];
  logic [15:0] slot_handle_mem [swsq_pkg::DEPTH];
  logic [31:0] slot_tmo_mem [swsq_pkg::DEPTH];
  logic [4:0]  win_size_reg;

  win_req_t          pending_reqs [$];
  swsq_pkg::result_t expected_results [$];
  int n_sent = 0;
  int n_accepted = 0;
  int err_cnt = 0;
  int gap_left = 0;
  int burst_left = 0;
  rx_mode_e rx_mode = RX_OPEN;
  int rx_mode_left = 0;
  int rx_stall_left = 0;

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int clamp_size(input logic [4:0] sz);
    if (sz == 5'd0) return 1;
    if (int'(sz) > swsq_pkg::WINDOW_MAX) return swsq_pkg::WINDOW_MAX;
    return int'(sz);
  endfunction

  // Apply one request to the window model and compute its result
  task automatic window_predict(input win_req_t r, output swsq_pkg::result_t res);
    int s, d, st, cnt, a, i, n;
    s   = clamp_size(win_size_reg);
    d   = int'(r.dest);
    st  = int'(win_start[d]);
    cnt = int'(win_count[d]);
    res = '0;
    case (r.req)
      swsq_pkg::REQ_APPEND: begin
        if (cnt >= s) begin
          res.status = swsq_pkg::STAT_FULL;
        end else begin
          a = d * swsq_pkg::WINDOW_MAX + (st + cnt) % s;
          slot_seq_mem[a]    = r.seq;
          slot_handle_mem[a] = r.handle;
          slot_tmo_mem[a]    = r.tmo;
          win_count[d]       = 5'(cnt + 1);
        end
      end
      swsq_pkg::REQ_DROP: begin
        n = (int'(r.ci) < cnt) ? int'(r.ci) : cnt;
        win_start[d] = 4'((st + n) % s);
        win_count[d] = 5'(cnt - n);
        res.dropped_count = 5'(n);
      end
      swsq_pkg::REQ_READ: begin
        if (int'(r.ci) >= cnt) begin
          res.status = swsq_pkg::STAT_BEYOND;
        end else begin
          a = d * swsq_pkg::WINDOW_MAX + (st + int'(r.ci)) % s;
          res.slot_seq     = slot_seq_mem[a];
          res.slot_handle  = slot_handle_mem[a];
          res.slot_timeout = slot_tmo_mem[a];
        end
      end
      default: begin
        // first match from the window start wins; a miss leaves all as is
        res.status = swsq_pkg::STAT_NOT_FOUND;
        for (i = 0; i < cnt; i++) begin
          a = d * swsq_pkg::WINDOW_MAX + (st + i) % s;
          if (slot_seq_mem[a] == r.seq) begin
            slot_tmo_mem[a]    = r.tmo;
            res.slot_seq       = slot_seq_mem[a];
            res.slot_handle    = slot_handle_mem[a];
            res.slot_timeout   = r.tmo;
            res.slot_position  = 4'(i);
            res.status         = swsq_pkg::STAT_OK;
            break;
          end
        end
      end
    endcase
    res.window_length = win_count[d];
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Monitor: result check, request prediction, register tracking
  always @(posedge clk) begin
    win_req_t          r;
    swsq_pkg::result_t exp_res, act_res;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        act_res.status        = out_tuser;
        act_res.window_length = out_tdata[4:0];
        act_res.slot_seq      = out_tdata[12:5];
        act_res.slot_handle   = out_tdata[28:13];
        act_res.slot_timeout  = out_tdata[60:29];
        act_res.slot_position = out_tdata[64:61];
        act_res.dropped_count = out_tdata[69:65];
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected (status %0d)", out_tuser);
          err_cnt++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("status", 32'(exp_res.status), 32'(act_res.status));
          check_field("window_length", 32'(exp_res.window_length),
                      32'(act_res.window_length));
          check_field("slot_seq", 32'(exp_res.slot_seq), 32'(act_res.slot_seq));
          check_field("slot_handle", 32'(exp_res.slot_handle),
                      32'(act_res.slot_handle));
          check_field("slot_timeout", exp_res.slot_timeout, act_res.slot_timeout);
          check_field("slot_position", 32'(exp_res.slot_position),
                      32'(act_res.slot_position));
          check_field("dropped_count", 32'(exp_res.dropped_count),
                      32'(act_res.dropped_count));
        end
      end
      if (in_tvalid && in_tready) begin
        r.req    = in_tuser;
        r.dest   = in_tdata[3:0];
        r.ci     = in_tdata[8:4];
        r.seq    = in_tdata[16:9];
        r.handle = in_tdata[32:17];
        r.tmo    = in_tdata[64:33];
        window_predict(r, exp_res);
        expected_results.push_back(exp_res);
        n_accepted <= n_accepted + 1;
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == ADDR_SLOT_LIMIT)
        win_size_reg = cfg_pwdata[4:0];
    end
  end

  // Request driver: bursts with random gaps, holds an item until transfer
  always @(negedge clk) begin
    win_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && n_sent != n_accepted) begin
      // waiting for the transfer
    end else if (gap_left > 0) begin
      in_tvalid <= 1'b0;
      gap_left--;
    end else if (pending_reqs.size() > 0) begin
      r = pending_reqs.pop_front();
      in_tvalid <= 1'b1;
      in_tuser  <= r.req;
      in_tdata  <= {7'b0, r.tmo, r.handle, r.seq, r.ci, r.dest};
      n_sent++;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 20);
        gap_left   = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result receiver: open, random or long stalls, mode changes now and then
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(50, 300);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 99) >= 35);
        default: begin
          if (rx_stall_left > 0) begin
            out_tready <= 1'b0;
            rx_stall_left--;
          end else if ($urandom_range(0, 99) < 10) begin
            rx_stall_left = $urandom_range(1, 20);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  function automatic void push_req(input logic [1:0] req, input logic [3:0] dest,
                                   input logic [4:0] ci, input logic [7:0] seq,
                                   input logic [15:0] handle, input logic [31:0] tmo);
    win_req_t r;
    r = '{req: req, dest: dest, ci: ci, seq: seq, handle: handle, tmo: tmo};
    pending_reqs.push_back(r);
  endfunction

  // Random request, mostly on a few destinations and a small set of sequences
  function automatic win_req_t random_window_req(input int s);
    win_req_t r;
    int pick;
    pick   = $urandom_range(0, 99);
    r.req  = (pick < 40) ? swsq_pkg::REQ_APPEND : (pick < 55) ? swsq_pkg::REQ_DROP :
             (pick < 80) ? swsq_pkg::REQ_READ : swsq_pkg::REQ_FIND;
    r.dest = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, FOCUS_DESTS - 1))
                                          : 4'($urandom_range(0, swsq_pkg::NUM_DEST - 1));
    pick = $urandom_range(0, 99);
    if (r.req == swsq_pkg::REQ_DROP)
      r.ci = (pick < 70) ? 5'($urandom_range(0, 3)) :
             (pick < 90) ? 5'($urandom_range(0, 16)) : 5'($urandom_range(0, 31));
    else
      r.ci = (pick < 80) ? 5'($urandom_range(0, s)) : 5'($urandom_range(0, 31));
    r.seq    = ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, 7))
                                            : 8'($urandom_range(0, 255));
    r.handle = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    r.tmo = (pick < 5) ? 32'h0 : (pick < 10) ? 32'hFFFF_FFFF : 32'($urandom);
    return r;
  endfunction

  // Empty every window so a size change never exposes stale slots
  function automatic void queue_drain();
    for (int d = 0; d < swsq_pkg::NUM_DEST; d++)
      push_req(swsq_pkg::REQ_DROP, 4'(d), 5'd31, 8'd0, 16'd0, 32'd0);
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || n_sent != n_accepted ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Main sequence
  initial begin
    logic [4:0] size_plan [9] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17,
                                  5'd3, 5'd12, 5'd8};
    for (int d = 0; d < swsq_pkg::NUM_DEST; d++) begin
      win_start[d] = '0;
      win_count[d] = '0;
    end
    for (int a = 0; a < swsq_pkg::DEPTH; a++) begin
      slot_seq_mem[a]    = '0;
      slot_handle_mem[a] = '0;
      slot_tmo_mem[a]    = '0;
    end
    win_size_reg = swsq_pkg::SLOT_LIMIT_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty window, fill to full, extremes, wrap, duplicates
    push_req(swsq_pkg::REQ_READ,   4'd0, 5'd0,  8'd0,   16'h0000, 32'h0);
    push_req(swsq_pkg::REQ_FIND,   4'd0, 5'd0,  8'd5,   16'h0000, 32'h1111_1111);
    push_req(swsq_pkg::REQ_DROP,   4'd0, 5'd3,  8'd0,   16'h0000, 32'h0);
    push_req(swsq_pkg::REQ_APPEND, 4'd0, 5'd0,  8'd0,   16'h0000, 32'h0000_0000);
    push_req(swsq_pkg::REQ_APPEND, 4'd0, 5'd31, 8'd255, 16'hFFFF, 32'hFFFF_FFFF);
    push_req(swsq_pkg::REQ_APPEND, 4'd0, 5'd0,  8'd7,   16'h1234, 32'h0000_0001);
    push_req(swsq_pkg::REQ_APPEND, 4'd0, 5'd0,  8'd7,   16'h4321, 32'h0000_0002);
    for (int k = 0; k < 4; k++)
      push_req(swsq_pkg::REQ_APPEND, 4'd0, 5'd0, 8'(9 + k), 16'(k * 16'h1111),
               32'($urandom));
    push_req(swsq_pkg::REQ_APPEND, 4'd0, 5'd0,  8'd13,  16'hBEEF, 32'h5);
    push_req(swsq_pkg::REQ_READ,   4'd0, 5'd7,  8'd0,   16'h0000, 32'h0);
    push_req(swsq_pkg::REQ_READ,   4'd0, 5'd8,  8'd0,   16'h0000, 32'h0);
    push_req(swsq_pkg::REQ_READ,   4'd0, 5'd31, 8'd0,   16'h0000, 32'h0);
    push_req(swsq_pkg::REQ_FIND,   4'd0, 5'd0,  8'd7,   16'h0000, 32'hAAAA_5555);
    push_req(swsq_pkg::REQ_FIND,   4'd0, 5'd0,  8'd255, 16'h0000, 32'h0);
    push_req(swsq_pkg::REQ_FIND,   4'd0, 5'd0,  8'd100, 16'h0000, 32'h2222_2222);
    push_req(swsq_pkg::REQ_DROP,   4'd0, 5'd3,  8'd0,   16'h0000, 32'h0);
    push_req(swsq_pkg::REQ_APPEND, 4'd0, 5'd0,  8'd20,  16'h00A0, 32'h20);
    push_req(swsq_pkg::REQ_APPEND, 4'd0, 5'd0,  8'd21,  16'h00A1, 32'h21);
    push_req(swsq_pkg::REQ_READ,   4'd0, 5'd6,  8'd0,   16'h0000, 32'h0);
    push_req(swsq_pkg::REQ_DROP,   4'd0, 5'd31, 8'd0,   16'h0000, 32'h0);
    push_req(swsq_pkg::REQ_APPEND, 4'd15, 5'd0, 8'd3,   16'h0F0F, 32'h3);
    push_req(swsq_pkg::REQ_DROP,   4'd15, 5'd16, 8'd0,  16'h0000, 32'h0);
    queue_drain();
    // sender holds off until every result is back
    wait_idle();

    // Random phases, each under its own window size
    foreach (size_plan[p]) begin
      apb_write(ADDR_SLOT_LIMIT, {27'($urandom), size_plan[p]});
      if (p == 0)
        apb_write(ADDR_UNUSED, 32'h0000_0003);
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        pending_reqs.push_back(random_window_req(clamp_size(win_size_reg)));
      queue_drain();
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (err_cnt == 0 && expected_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
